@@ hdl/esm_pkg.sv @@
// Package for the exact stamp match release queue.
// Holds the command, result and configuration types, codes and a shared helper.
// No dependencies.
package esm_pkg;

  localparam int unsigned DEPTH_DEFAULT    = 32;
  localparam int unsigned TAG_BITS_DEFAULT = 16;

  localparam logic [5:0]  DEPTH_LIMIT_RESET = 6'd30;
  localparam logic [15:0] WAIT_LIMIT_RESET  = 16'd500;

  // Register indexes on the configuration port.
  localparam logic REG_DEPTH_LIMIT = 1'b0;
  localparam logic REG_WAIT_LIMIT  = 1'b1;

  // Command opcodes; the unused code behaves as a tick.
  localparam logic [1:0] OP_IMAGE  = 2'd0;
  localparam logic [1:0] OP_DETECT = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Release causes.
  localparam logic [1:0] CAUSE_MATCHED = 2'd0;
  localparam logic [1:0] CAUSE_TIMEOUT = 2'd1;
  localparam logic [1:0] CAUSE_EVICTED = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] stamp_seconds;
    logic [29:0]        stamp_nanoseconds;
    logic [15:0]        item_tag;
    logic [31:0]        current_time;
  } cmd_t;

  typedef struct packed {
    logic [15:0] frame_tag;
    logic [15:0] detection_tag;
    logic        has_detection;
    logic [1:0]  release_cause;
    logic [31:0] timeout_total;
    logic [31:0] pressure_total;
    logic [31:0] missed_total;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [5:0]  depth_limit;
    logic [15:0] wait_limit;
  } cfg_t;

  // Events from the sequencer to the result staging.
  typedef struct packed {
    logic gen;
    logic done;
    res_t rel;
  } evt_t;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

endpackage

@@ hdl/exact_stamp_match_release_queue.sv @@
// Top level of the exact stamp match release queue.
// Depends on esm_pkg, esm_apb_regs and esm_seq (which holds esm_ram).
//
// Usage. A command (image, detection or tick) is transferred on cmd_i at a
// rising edge with start high and busy low. Each released frame appears on
// res_o for exactly one cycle with res_valid_o high; the receiver cannot
// stall, so every result must be taken in that cycle. The final result of a
// command carries last. A command that releases nothing gives no result.
// Sequence while busy: an image writes its frame, with evictions; a
// detection compares the entries one at a time up to the match, or the whole
// queue on a miss, as the entry memory has a single read port; a tick does
// neither. Every command then drains the head and finishes. A result is held
// until the next release of its command, or the end of the command, shows
// whether it is the last, so the final one appears in the cycle after busy
// falls. The user must write configuration over the APB port only while the
// block is idle; the block itself does not enforce this. Reset empties the
// queue, clears the counters and loads the limits with their defaults; the
// entry memory itself is not cleared.
module exact_stamp_match_release_queue
  import esm_pkg::*;
#(
  parameter int unsigned DEPTH    = DEPTH_DEFAULT,
  parameter int unsigned TAG_BITS = TAG_BITS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd_i,
  output logic        res_valid_o,
  output res_t        res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  evt_t evt;
  res_t pend_q, res_q, res_d;
  logic pend_v_q, res_v_q;

  esm_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  esm_seq #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_i   (cmd_i),
    .cfg_i   (cfg),
    .busy_o  (busy),
    .evt_o   (evt)
  );

  // One result is held back until the next one, or the end of the command,
  // shows whether it is the last.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      res_v_q <= 1'b0;
      if (evt.gen) begin
        res_v_q  <= pend_v_q;
        pend_v_q <= 1'b1;
      end else if (evt.done) begin
        res_v_q  <= pend_v_q;
        pend_v_q <= 1'b0;
      end
    end
  end

  always_comb begin
    res_d      = pend_q;
    res_d.last = evt.done;
  end

  always_ff @(posedge clk_i) begin
    if (evt.gen) begin
      res_q  <= res_d;
      pend_q <= evt.rel;
    end else if (evt.done) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

endmodule

@@ hdl/esm_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module esm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ hdl/esm_apb_regs.sv @@
// APB-style configuration registers: depth limit and wait limit.
// Depends on esm_pkg.
module esm_apb_regs
  import esm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [5:0]  depth_limit_q;
  logic [15:0] wait_limit_q;
  logic        reg_idx;

  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_limit_q <= DEPTH_LIMIT_RESET;
      wait_limit_q  <= WAIT_LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_DEPTH_LIMIT: depth_limit_q <= pwdata[5:0];
        REG_WAIT_LIMIT:  wait_limit_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEPTH_LIMIT: prdata = {26'd0, depth_limit_q};
      REG_WAIT_LIMIT:  prdata = {16'd0, wait_limit_q};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o.depth_limit = depth_limit_q;
  assign cfg_o.wait_limit  = wait_limit_q;

endmodule

@@ hdl/esm_seq.sv @@
// Frame queue sequencer: entry memory, head/tail pointers, counters and the
// read-modify-write state machine that appends, matches, evicts and drains.
// Depends on esm_pkg and esm_ram.
module esm_seq
  import esm_pkg::*;
#(
  parameter int unsigned DEPTH    = DEPTH_DEFAULT,
  parameter int unsigned TAG_BITS = TAG_BITS_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  cmd_t cmd_i,
  input  cfg_t cfg_i,
  output logic busy_o,
  output evt_t evt_o
);

  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  // Entry layout: matched flag, detection tag, frame tag, arrival time, stamp.
  localparam int unsigned D_LO    = 1;
  localparam int unsigned F_LO    = 1 + TAG_BITS;
  localparam int unsigned A_LO    = 1 + 2 * TAG_BITS;
  localparam int unsigned S_LO    = 33 + 2 * TAG_BITS;
  localparam int unsigned ENTRY_W = 95 + 2 * TAG_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_EVICT_RD,
    S_EVICT_EMIT,
    S_SCAN,
    S_DRAIN_RD,
    S_DRAIN_CHK,
    S_FLUSH
  } state_e;

  state_e            state_q;
  cmd_t              cmd_q;
  logic [IDX_W-1:0]  head_q, tail_q, scan_ptr_q, slot_q;
  logic [CNT_W-1:0]  count_q, scan_left_q;
  logic              inflight_q, wr_pend_q;
  logic [31:0]       timeout_q, pressure_q, missed_q;
  logic              gen_q, done_q;
  res_t              rel_q;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic [CNT_W-1:0]  lim;
  logic [TAG_BITS-1:0] tag_in;
  logic [61:0]       stamp_in;
  logic              scan_hit;
  logic [31:0]       age;
  logic              aged_out;
  logic [15:0]       rd_ftag, rd_dtag;

  function automatic logic [IDX_W-1:0] next_idx(logic [IDX_W-1:0] x);
    return (x == IDX_W'(DEPTH - 1)) ? '0 : x + IDX_W'(1);
  endfunction

  function automatic logic [TAG_BITS-1:0] tag_from16(logic [15:0] v);
    logic [TAG_BITS-1:0] r;
    r = '0;
    for (int b = 0; b < TAG_BITS && b < 16; b++) r[b] = v[b];
    return r;
  endfunction

  function automatic logic [15:0] tag_to16(logic [TAG_BITS-1:0] v);
    logic [15:0] r;
    r = '0;
    for (int b = 0; b < TAG_BITS && b < 16; b++) r[b] = v[b];
    return r;
  endfunction

  esm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (cfg_i.depth_limit == '0) begin
      lim = CNT_W'(1);
    end else if (32'(cfg_i.depth_limit) > 32'(DEPTH)) begin
      lim = CNT_W'(DEPTH);
    end else begin
      lim = CNT_W'(cfg_i.depth_limit);
    end
  end

  assign tag_in   = tag_from16(cmd_q.item_tag);
  assign stamp_in = {cmd_q.stamp_seconds, cmd_q.stamp_nanoseconds};
  assign scan_hit = inflight_q && (ram_rdata[S_LO +: 62] == stamp_in);
  assign age      = cmd_q.current_time - ram_rdata[A_LO +: 32];
  assign aged_out = age >= {16'd0, cfg_i.wait_limit};
  assign rd_ftag  = tag_to16(ram_rdata[F_LO +: TAG_BITS]);
  assign rd_dtag  = tag_to16(ram_rdata[D_LO +: TAG_BITS]);

  // Memory port control. The scan issues one read per cycle and checks the
  // entry read in the previous cycle; a hit is written back at once.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail_q;
    ram_wdata = {stamp_in, cmd_q.current_time, tag_in, {TAG_BITS{1'b0}}, 1'b0};
    ram_re    = 1'b0;
    ram_raddr = head_q;
    case (state_q)
      S_WRITE: begin
        ram_we = 1'b1;
      end
      S_EVICT_RD, S_DRAIN_RD: begin
        ram_re = 1'b1;
      end
      S_SCAN: begin
        if (scan_hit) begin
          ram_we    = 1'b1;
          ram_waddr = slot_q;
          ram_wdata = {ram_rdata[ENTRY_W-1:F_LO], tag_in, 1'b1};
        end else if (scan_left_q != '0) begin
          ram_re    = 1'b1;
          ram_raddr = scan_ptr_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      scan_ptr_q  <= '0;
      slot_q      <= '0;
      count_q     <= '0;
      scan_left_q <= '0;
      inflight_q  <= 1'b0;
      wr_pend_q   <= 1'b0;
      timeout_q   <= '0;
      pressure_q  <= '0;
      missed_q    <= '0;
      gen_q       <= 1'b0;
      done_q      <= 1'b0;
      rel_q       <= '0;
    end else begin
      gen_q  <= 1'b0;
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            cmd_q <= cmd_i;
            case (cmd_i.opcode)
              OP_IMAGE: begin
                // A full queue loses its head before the new frame goes in.
                if (count_q == CNT_W'(DEPTH)) begin
                  wr_pend_q <= 1'b1;
                  state_q   <= S_EVICT_RD;
                end else begin
                  state_q <= S_WRITE;
                end
              end
              OP_DETECT: begin
                scan_ptr_q  <= head_q;
                scan_left_q <= count_q;
                inflight_q  <= 1'b0;
                state_q     <= S_SCAN;
              end
              default: state_q <= S_DRAIN_RD;
            endcase
          end
        end
        S_WRITE: begin
          tail_q    <= next_idx(tail_q);
          count_q   <= count_q + CNT_W'(1);
          wr_pend_q <= 1'b0;
          state_q   <= (count_q >= lim) ? S_EVICT_RD : S_DRAIN_RD;
        end
        S_EVICT_RD: begin
          state_q <= S_EVICT_EMIT;
        end
        S_EVICT_EMIT: begin
          pressure_q              <= sat_inc(pressure_q);
          gen_q                   <= 1'b1;
          rel_q.frame_tag         <= rd_ftag;
          rel_q.detection_tag     <= '0;
          rel_q.has_detection     <= 1'b0;
          rel_q.release_cause     <= CAUSE_EVICTED;
          rel_q.timeout_total     <= timeout_q;
          rel_q.pressure_total    <= sat_inc(pressure_q);
          rel_q.missed_total      <= missed_q;
          rel_q.last              <= 1'b0;
          head_q                  <= next_idx(head_q);
          count_q                 <= count_q - CNT_W'(1);
          if (wr_pend_q) begin
            state_q <= S_WRITE;
          end else if ((count_q - CNT_W'(1)) > lim) begin
            state_q <= S_EVICT_RD;
          end else begin
            state_q <= S_DRAIN_RD;
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            inflight_q <= 1'b0;
            state_q    <= S_DRAIN_RD;
          end else if (scan_left_q == '0) begin
            inflight_q <= 1'b0;
            missed_q   <= sat_inc(missed_q);
            state_q    <= S_DRAIN_RD;
          end else begin
            inflight_q  <= 1'b1;
            slot_q      <= scan_ptr_q;
            scan_ptr_q  <= next_idx(scan_ptr_q);
            scan_left_q <= scan_left_q - CNT_W'(1);
          end
        end
        S_DRAIN_RD: begin
          state_q <= (count_q == '0) ? S_FLUSH : S_DRAIN_CHK;
        end
        S_DRAIN_CHK: begin
          if (ram_rdata[0] || aged_out) begin
            gen_q                <= 1'b1;
            rel_q.frame_tag      <= rd_ftag;
            rel_q.pressure_total <= pressure_q;
            rel_q.missed_total   <= missed_q;
            rel_q.last           <= 1'b0;
            if (ram_rdata[0]) begin
              rel_q.detection_tag <= rd_dtag;
              rel_q.has_detection <= 1'b1;
              rel_q.release_cause <= CAUSE_MATCHED;
              rel_q.timeout_total <= timeout_q;
            end else begin
              timeout_q           <= sat_inc(timeout_q);
              rel_q.detection_tag <= '0;
              rel_q.has_detection <= 1'b0;
              rel_q.release_cause <= CAUSE_TIMEOUT;
              rel_q.timeout_total <= sat_inc(timeout_q);
            end
            head_q  <= next_idx(head_q);
            count_q <= count_q - CNT_W'(1);
            state_q <= S_DRAIN_RD;
          end else begin
            state_q <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o    = (state_q != S_IDLE);
  assign evt_o.gen  = gen_q;
  assign evt_o.done = done_q;
  assign evt_o.rel  = rel_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count above capacity");

  a_gen_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(gen_q && done_q))
    else $error("release and completion in the same cycle");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_WRITE || state_q == S_SCAN))
    else $error("entry memory written outside append or match");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted command did not make the block busy");

  a_timeout_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (timeout_q == '1) |=> (timeout_q == '1))
    else $error("timeout counter wrapped");

endmodule
